// ----- rtl/core/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared port widths and result codes for the deduplicating slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

	localparam int KEY_PORT_W  = 48;
	localparam int SLOT_PORT_W = 8;
	localparam int STATUS_W    = 3;
	localparam int IN_DATA_W   = 56;	// key, slot
	localparam int OUT_DATA_W  = 16;	// slot_out, status, zero fill

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 3'd0,
		ST_ALLOC    = 3'd1,
		ST_FULL     = 3'd2,
		ST_NULL     = 3'd3,
		ST_RELEASED = 3'd4,
		ST_IGNORED  = 3'd5
	} status_t;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

endpackage

// ----- rtl/core/dsa_ram.sv -----
// ----------------------------------------------------------------------------
// dsa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/deduplicating_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// deduplicating_slot_allocator_top
// Binds nonzero keys to table slots without duplicates, using a LIFO free
// stack of slots; release transactions return bound slots to the stack.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (tdata / tuser, low bit first)
// s_axis    in   tdata: key[47:0], slot[55:48]   tuser: op
// m_axis    out  tdata: slot_out[7:0], status[10:8], zeros[15:11]
//
// After reset the key table is swept to zero with s_axis_tready low. An
// acquire scans the key table one entry per cycle through the read port of
// the key RAM, stopping early on a hit, with a pop state when the popped
// slot comes from the stack RAM. A null key, or a release with a slot beyond
// the table, goes straight to the finish state; other releases pass through
// the release state. One transaction is worked at a time; a finished result
// waits in the output register while the next input is taken, and the
// sequencer holds only when a second result finds that register still full.
//
module deduplicating_slot_allocator_top #(
	parameter int SLOTS    = 256,
	parameter int KEY_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [dsa_pkg::IN_DATA_W-1:0]   s_axis_tdata,	// key[47:0], slot[55:48]
	input  logic                            s_axis_tuser,	// op
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata	// slot_out[7:0], status[10:8]
);

	localparam int KW = (KEY_BITS < dsa_pkg::KEY_PORT_W) ? KEY_BITS : dsa_pkg::KEY_PORT_W;
	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = SW + dsa_pkg::SLOT_PORT_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_POP,
		S_REL,
		S_FIN
	} state_t;

	state_t state_q;

	logic [KW-1:0]                   key_q;
	logic [SW-1:0]                   idx_q;
	logic [SW-1:0]                   clr_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   min_q;
	logic [dsa_pkg::SLOT_PORT_W-1:0] res_slot_q;
	dsa_pkg::status_t                res_status_q;

	// incoming fields
	logic [KW-1:0]                   in_key;
	logic [dsa_pkg::SLOT_PORT_W-1:0] in_slot;
	logic [XW-1:0]                   in_slot_ext;
	logic [SW-1:0]                   in_slot_idx;
	logic                            in_slot_ok;
	logic                            in_op;
	logic                            take;

	// key RAM
	logic          key_we;
	logic [SW-1:0] key_waddr;
	logic [KW-1:0] key_wdata;
	logic [SW-1:0] key_raddr;
	logic [KW-1:0] key_rdata;

	// free stack RAM
	logic          stk_we;
	logic [SW-1:0] stk_waddr;
	logic [SW-1:0] stk_raddr;
	logic [SW-1:0] stk_rdata;

	logic [CW-1:0] count_dec;
	logic [SW-1:0] fresh_slot;
	logic          hit;
	logic          scan_end;
	logic          fresh;
	logic          rel_ok;
	logic          out_free;
	logic [XW-1:0] idx_ext;
	logic [XW-1:0] stk_ext;
	logic [XW-1:0] fresh_ext;

	assign in_key      = s_axis_tdata[KW-1:0];
	assign in_slot     = s_axis_tdata[dsa_pkg::KEY_PORT_W +: dsa_pkg::SLOT_PORT_W];
	assign in_slot_ext = {{SW{1'b0}}, in_slot};
	assign in_slot_idx = in_slot_ext[SW-1:0];
	assign in_slot_ok  = (in_slot_ext < XW'(SLOTS));
	assign in_op       = s_axis_tuser;

	assign s_axis_tready = (state_q == S_IDLE);
	assign take          = s_axis_tvalid && s_axis_tready;

	assign count_dec  = count_q - CW'(1);
	assign fresh_slot = SW'(CW'(SLOTS) - count_q);
	// a bound slot always holds a nonzero key, so a match is a bound hit
	assign hit        = (key_rdata == key_q);
	assign scan_end   = (idx_q == SW'(SLOTS - 1));
	// stack entries below the lowest count seen since reset were never pushed
	assign fresh      = (count_q == min_q);
	assign rel_ok     = (key_rdata != '0) && (count_q < CW'(SLOTS));
	assign out_free   = !m_axis_tvalid || m_axis_tready;
	assign idx_ext    = {{dsa_pkg::SLOT_PORT_W{1'b0}}, idx_q};
	assign stk_ext    = {{dsa_pkg::SLOT_PORT_W{1'b0}}, stk_rdata};
	assign fresh_ext  = {{dsa_pkg::SLOT_PORT_W{1'b0}}, fresh_slot};

	assign stk_raddr = count_dec[SW-1:0];
	assign stk_waddr = count_q[SW-1:0];
	assign stk_we    = (state_q == S_REL) && rel_ok;

	always_comb begin
		key_we    = 1'b0;
		key_waddr = clr_q;
		key_wdata = '0;
		key_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				key_we = 1'b1;
			end
			S_IDLE: begin
				key_raddr = (in_op == dsa_pkg::OP_RELEASE) ? in_slot_idx : '0;
			end
			S_SCAN: begin
				key_raddr = idx_q + SW'(1);
				if (!hit && scan_end && count_q != '0 && fresh) begin
					key_we    = 1'b1;
					key_waddr = fresh_slot;
					key_wdata = key_q;
				end
			end
			S_POP: begin
				key_we    = 1'b1;
				key_waddr = stk_rdata;
				key_wdata = key_q;
			end
			S_REL: begin
				key_we    = rel_ok;
				key_waddr = idx_q;
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	dsa_ram #(
		.WIDTH (KW),
		.DEPTH (SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	dsa_ram #(
		.WIDTH (SW),
		.DEPTH (SLOTS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (idx_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			count_q       <= CW'(SLOTS);
			min_q         <= CW'(SLOTS);
			m_axis_tvalid <= 1'b0;
		end else begin
			// S_FIN reloads the output register itself
			if (m_axis_tvalid && m_axis_tready && state_q != S_FIN) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						key_q  <= in_key;
						idx_q  <= (in_op == dsa_pkg::OP_RELEASE) ? in_slot_idx : '0;
						if (in_op == dsa_pkg::OP_RELEASE) begin
							res_slot_q <= in_slot;
							if (in_slot_ok) begin
								state_q <= S_REL;
							end else begin
								res_status_q <= dsa_pkg::ST_IGNORED;
								state_q      <= S_FIN;
							end
						end else if (in_key == '0) begin
							res_slot_q   <= '0;
							res_status_q <= dsa_pkg::ST_NULL;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_slot_q   <= idx_ext[dsa_pkg::SLOT_PORT_W-1:0];
						res_status_q <= dsa_pkg::ST_FOUND;
						state_q      <= S_FIN;
					end else if (scan_end) begin
						if (count_q == '0) begin
							res_slot_q   <= '0;
							res_status_q <= dsa_pkg::ST_FULL;
							state_q      <= S_FIN;
						end else if (fresh) begin
							// pop a slot that was never pushed: its value is implied
							count_q      <= count_dec;
							min_q        <= count_dec;
							res_slot_q   <= fresh_ext[dsa_pkg::SLOT_PORT_W-1:0];
							res_status_q <= dsa_pkg::ST_ALLOC;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_POP;
						end
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_POP: begin
					count_q      <= count_dec;
					res_slot_q   <= stk_ext[dsa_pkg::SLOT_PORT_W-1:0];
					res_status_q <= dsa_pkg::ST_ALLOC;
					state_q      <= S_FIN;
				end
				S_REL: begin
					if (rel_ok) begin
						count_q      <= count_q + CW'(1);
						res_status_q <= dsa_pkg::ST_RELEASED;
					end else begin
						res_status_q <= dsa_pkg::ST_IGNORED;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register can take the result
					if (out_free) begin
						m_axis_tdata  <= {{(dsa_pkg::OUT_DATA_W - dsa_pkg::SLOT_PORT_W -
							dsa_pkg::STATUS_W){1'b0}}, res_status_q, res_slot_q};
						m_axis_tvalid <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
